// ===== design/ptrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrt_pkg: shared types and constants for the periodic task ready table
// Slot geometry, opcode and status codes, the slot memory word and the
// request bundle that the controller drives into the slot memory.
// ----------------------------------------------------------------------------
package ptrt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam int OP_W     = 2;
  localparam int PERIOD_W = 16;
  localparam int INDEX_W  = 4;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 3;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IDX_W  = SLOT_W + 1;
  localparam int RES_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int WORD_W = 2 * COUNT_WIDTH;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED    = 3'd0,
    ST_FULL       = 3'd1,
    ST_DISPATCHED = 3'd2,
    ST_NONE       = 3'd3,
    ST_ACK        = 3'd4
  } status_t;

  // one memory word per slot
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] period;
    logic [COUNT_WIDTH-1:0] count;
  } slot_word_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    slot_word_t        wdata;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } find_t;

  // lowest set bit of a slot vector
  function automatic find_t first_set(input logic [NUM_SLOTS-1:0] vec);
    find_t res;
    res = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.found = 1'b1;
        res.idx   = SLOT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== design/periodic_task_ready_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_ready_table_top: periodic cooperative task slot table
// Slot period and tick count live in a RAM with a registered read port; a sequencer
// handles create, delete, timer tick and dispatch commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Create and delete
// finish at once: their single result beat appears on the next cycle. A
// timer tick walks the slot RAM one slot per cycle through a read-modify-
// write pipeline and holds busy until the last slot is written back, its
// acknowledge beat following right after. Dispatch with nothing ready
// answers on the next cycle; otherwise it emits one beat per ready slot on
// consecutive cycles, lowest slot first, with last set on the final beat.
// Each result beat is valid for exactly one cycle on strobe and cannot be
// held off, so the receiver must take every beat as it comes.
// ----------------------------------------------------------------------------
module periodic_task_ready_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ptrt_pkg::OP_W-1:0]     operation,
  input  logic [ptrt_pkg::PERIOD_W-1:0] task_period,
  input  logic [ptrt_pkg::INDEX_W-1:0]  slot_index,
  output logic                          strobe,
  output logic [ptrt_pkg::ID_W-1:0]     slot_id,
  output logic [ptrt_pkg::STATUS_W-1:0] status,
  output logic                          last
);
  import ptrt_pkg::*;

  ram_req_t   ram_req;
  slot_word_t ram_rdata;

  // command sequencer
  ptrt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .task_period (task_period),
    .slot_index  (slot_index),
    .strobe      (strobe),
    .slot_id     (slot_id),
    .status      (status),
    .last        (last),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  // slot period and tick count storage
  ptrt_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== design/ptrt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrt_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ptrt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ptrt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrt_ctrl: command sequencer for the periodic task ready table
// Holds the active and ready marks, walks the slot memory on a tick with a
// read-modify-write pipeline, and streams dispatch results one per cycle.
// ----------------------------------------------------------------------------
module ptrt_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [ptrt_pkg::OP_W-1:0]           operation,
  input  logic [ptrt_pkg::PERIOD_W-1:0]       task_period,
  input  logic [ptrt_pkg::INDEX_W-1:0]        slot_index,
  output logic                                strobe,
  output logic [ptrt_pkg::ID_W-1:0]           slot_id,
  output logic [ptrt_pkg::STATUS_W-1:0]       status,
  output logic                                last,
  output ptrt_pkg::ram_req_t                  ram_req,
  input  ptrt_pkg::slot_word_t                ram_rdata
);
  import ptrt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DISP
  } state_t;

  state_t               state;
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] ready;
  logic [IDX_W-1:0]     rd_idx;
  logic                 wb_valid;
  logic [SLOT_W-1:0]    wb_idx;
  logic [RES_W-1:0]     n_sent;

  op_t                    op;
  find_t                  free_slot;
  find_t                  pick;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_next;
  logic                   hit;
  logic [NUM_SLOTS-1:0]   rest_ready;
  logic                   disp_last;
  logic                   del_in_range;
  logic [SLOT_W-1:0]      del_idx;

  assign op           = op_t'(operation);
  assign free_slot    = first_set(~active);
  assign pick         = first_set(ready);
  assign del_in_range = int'(slot_index) < NUM_SLOTS;
  assign del_idx      = SLOT_W'(slot_index);
  assign busy         = (state != S_IDLE);

  // advance the tick count of the slot coming back from memory
  assign cnt_inc  = ram_rdata.count + COUNT_WIDTH'(1);
  assign hit      = (cnt_inc == ram_rdata.period);
  assign cnt_next = hit ? '0 : cnt_inc;

  // last dispatch beat: no ready slot left above, or result cap reached
  assign rest_ready = ready & ~(NUM_SLOTS'(1) << pick.idx);
  assign disp_last  = (rest_ready == '0) || (n_sent == RES_W'(MAX_RESULTS - 1));

  // drive the slot memory: create writes, tick writes back
  always_comb begin
    ram_req       = '0;
    ram_req.raddr = rd_idx[SLOT_W-1:0];
    priority if (state == S_IDLE && start && op == OP_CREATE && free_slot.found) begin
      ram_req.we           = 1'b1;
      ram_req.waddr        = free_slot.idx;
      ram_req.wdata.period = COUNT_WIDTH'(task_period);
      ram_req.wdata.count  = '0;
    end else if (state == S_TICK && wb_valid && active[wb_idx]) begin
      ram_req.we           = 1'b1;
      ram_req.waddr        = wb_idx;
      ram_req.wdata.period = ram_rdata.period;
      ram_req.wdata.count  = cnt_next;
    end else begin
      ram_req.we = 1'b0;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      active   <= '0;
      ready    <= '0;
      rd_idx   <= '0;
      wb_valid <= 1'b0;
      n_sent   <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (op)
              OP_CREATE: begin
                strobe <= 1'b1;
                last   <= 1'b1;
                if (free_slot.found) begin
                  active[free_slot.idx] <= 1'b1;
                  ready[free_slot.idx]  <= 1'b0;
                  slot_id               <= ID_W'(free_slot.idx);
                  status                <= ST_CREATED;
                end else begin
                  slot_id <= '0;
                  status  <= ST_FULL;
                end
              end
              OP_DELETE: begin
                if (del_in_range) begin
                  active[del_idx] <= 1'b0;
                  ready[del_idx]  <= 1'b0;
                end
                strobe  <= 1'b1;
                last    <= 1'b1;
                slot_id <= '0;
                status  <= ST_ACK;
              end
              OP_TICK: begin
                state    <= S_TICK;
                rd_idx   <= '0;
                wb_valid <= 1'b0;
              end
              OP_DISPATCH: begin
                if (ready == '0) begin
                  strobe  <= 1'b1;
                  last    <= 1'b1;
                  slot_id <= '0;
                  status  <= ST_NONE;
                end else begin
                  state  <= S_DISP;
                  n_sent <= '0;
                end
              end
            endcase
          end
        end
        S_TICK: begin
          // issue one read per cycle, write back in the next cycle
          if (rd_idx < IDX_W'(NUM_SLOTS)) begin
            rd_idx   <= rd_idx + IDX_W'(1);
            wb_valid <= 1'b1;
            wb_idx   <= rd_idx[SLOT_W-1:0];
          end else begin
            wb_valid <= 1'b0;
          end
          if (wb_valid && active[wb_idx] && hit) begin
            ready[wb_idx] <= 1'b1;
          end
          if (wb_valid && wb_idx == SLOT_W'(NUM_SLOTS - 1)) begin
            strobe  <= 1'b1;
            last    <= 1'b1;
            slot_id <= '0;
            status  <= ST_ACK;
            state   <= S_IDLE;
          end
        end
        S_DISP: begin
          // drop the lowest ready mark and report it
          ready[pick.idx] <= 1'b0;
          strobe          <= 1'b1;
          last            <= disp_last;
          slot_id         <= ID_W'(pick.idx);
          status          <= ST_DISPATCHED;
          n_sent          <= n_sent + RES_W'(1);
          if (disp_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/ptrt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrt_checker: port-level checks for the periodic task ready table
// Watches command acceptance and the result beat stream over time.
// ----------------------------------------------------------------------------
module ptrt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          strobe,
  input logic [ptrt_pkg::ID_W-1:0]     slot_id,
  input logic [ptrt_pkg::STATUS_W-1:0] status,
  input logic                          last
);
  import ptrt_pkg::*;

  // an accepted command either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> strobe || busy)
    else $error("accepted command neither answered nor went busy");

  // a non-final beat is followed by another beat
  a_stream_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("result stream broken before last beat");

  // a non-final beat only comes from dispatch, while still busy
  a_nonlast_dispatch: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy && status == ST_DISPATCHED)
    else $error("non-final beat outside a dispatch");

  // statuses that name no slot report slot zero
  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == ST_ACK || status == ST_NONE || status == ST_FULL)
      |-> slot_id == '0)
    else $error("slot id set on a status without a slot");

endmodule

bind periodic_task_ready_table_top ptrt_checker u_ptrt_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .strobe  (strobe),
  .slot_id (slot_id),
  .status  (status),
  .last    (last)
);
